// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape.
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharB      = 8'h62;
  localparam logic [7:0] CharF      = 8'h66;
  localparam logic [7:0] CharN      = 8'h6E;
  localparam logic [7:0] CharR      = 8'h72;
  localparam logic [7:0] CharT      = 8'h74;
  localparam logic [7:0] CharU      = 8'h75;

  localparam logic [7:0] CtlBs = 8'h08;
  localparam logic [7:0] CtlFf = 8'h0C;
  localparam logic [7:0] CtlLf = 8'h0A;
  localparam logic [7:0] CtlCr = 8'h0D;
  localparam logic [7:0] CtlHt = 8'h09;

  typedef enum logic [3:0] {
    MODE_WAIT   = 4'd0,
    MODE_TEXT   = 4'd1,
    MODE_ESC    = 4'd2,
    MODE_HEXHI  = 4'd3,
    MODE_PAIRBS = 4'd4,
    MODE_PAIRU  = 4'd5,
    MODE_HEXLO  = 4'd6
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_QUOTE = 2'd1,
    KIND_NUL   = 2'd2,
    KIND_NOSTR = 2'd3
  } kind_e;

  // One queued result group: a code point (len = byte count - 1) or a terminator.
  typedef struct packed {
    kind_e       kind;
    logic [1:0]  len;
    logic [20:0] cp;
  } cmd_t;

endpackage

// ===== rtl/jsu_front.sv =====
// Front end: accepts input words, tracks string/escape/hex state and
// issues one command per word that gives results. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  mode_e       mode_q, mode_d;
  logic [15:0] hex_value_q, hex_value_d;
  logic [1:0]  hex_count_q, hex_count_d;
  logic        hex_bad_q, hex_bad_d;
  logic [9:0]  high_q, high_d;

  logic push;

  // plain text byte
  logic  t_push, t_end;
  mode_e t_mode;
  cmd_t  t_cmd;
  // escaped byte
  logic  e_push, e_end;
  mode_e e_mode;
  cmd_t  e_cmd;
  // hex digit
  logic [3:0]  dig;
  logic        is_dig;
  logic [15:0] hv_n, v;
  logic        bad_n, hex_done, v_zero, v_low, v_high;
  logic [20:0] pair_cp;

  function automatic logic [1:0] utf8_len(logic [20:0] cp);
    if (cp < 21'h80) begin
      return 2'd0;
    end else if (cp < 21'h800) begin
      return 2'd1;
    end else if (cp < 21'h10000) begin
      return 2'd2;
    end
    return 2'd3;
  endfunction

  always_comb begin
    t_push = 1'b0;
    t_end  = 1'b0;
    t_mode = MODE_TEXT;
    t_cmd  = '{kind: KIND_DATA, len: 2'd0, cp: {13'd0, byte_i}};
    if (byte_i == CharQuote) begin
      t_push = 1'b1;
      t_end  = 1'b1;
      t_cmd  = '{kind: KIND_QUOTE, len: 2'd0, cp: 21'd0};
    end else if (byte_i == CharNul) begin
      t_push = 1'b1;
      t_end  = 1'b1;
      t_cmd  = '{kind: KIND_NUL, len: 2'd0, cp: 21'd0};
    end else if (byte_i == CharBslash) begin
      t_mode = MODE_ESC;
    end else begin
      t_push = 1'b1;
    end
  end

  always_comb begin
    e_push = 1'b1;
    e_end  = 1'b0;
    e_mode = MODE_TEXT;
    e_cmd  = '{kind: KIND_DATA, len: 2'd0, cp: {13'd0, byte_i}};
    case (byte_i)
      CharB: e_cmd.cp = {13'd0, CtlBs};
      CharF: e_cmd.cp = {13'd0, CtlFf};
      CharN: e_cmd.cp = {13'd0, CtlLf};
      CharR: e_cmd.cp = {13'd0, CtlCr};
      CharT: e_cmd.cp = {13'd0, CtlHt};
      CharU: begin
        e_push = 1'b0;
        e_mode = MODE_HEXHI;
      end
      CharNul: begin
        e_end = 1'b1;
        e_cmd = '{kind: KIND_NUL, len: 2'd0, cp: 21'd0};
      end
      default: ;
    endcase
  end

  always_comb begin
    dig    = 4'd0;
    is_dig = 1'b1;
    if (byte_i inside {[8'h30:8'h39]}) begin
      dig = byte_i[3:0];
    end else if (byte_i inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      dig = byte_i[3:0] + 4'd9;
    end else begin
      is_dig = 1'b0;
    end
    hv_n     = {hex_value_q[11:0], dig};
    bad_n    = hex_bad_q | ~is_dig;
    v        = bad_n ? 16'd0 : hv_n;
    hex_done = (hex_count_q == 2'd3);
    v_zero   = (v == 16'd0);
    v_low    = (v[15:10] == 6'b110111);
    v_high   = (v[15:10] == 6'b110110);
    pair_cp  = 21'h10000 + {1'b0, high_q, v[9:0]};
  end

  // next state
  always_comb begin
    logic fin;
    fin         = 1'b0;
    mode_d      = mode_q;
    hex_value_d = hex_value_q;
    hex_count_d = hex_count_q;
    hex_bad_d   = hex_bad_q;
    high_d      = high_q;
    case (mode_q)
      MODE_TEXT: begin
        mode_d = t_mode;
        fin    = t_end;
      end
      MODE_ESC: begin
        mode_d = e_mode;
        fin    = e_end;
        if (e_mode == MODE_HEXHI) begin
          hex_value_d = '0;
          hex_count_d = '0;
          hex_bad_d   = 1'b0;
        end
      end
      MODE_HEXHI, MODE_HEXLO: begin
        if (byte_i == CharNul) begin
          fin = 1'b1;
        end else if (!hex_done) begin
          hex_value_d = hv_n;
          hex_bad_d   = bad_n;
          hex_count_d = hex_count_q + 2'd1;
        end else begin
          hex_value_d = '0;
          hex_count_d = '0;
          hex_bad_d   = 1'b0;
          mode_d      = MODE_TEXT;
          if (mode_q == MODE_HEXLO) begin
            high_d = '0;
          end else if (v_high) begin
            high_d = v[9:0];
            mode_d = MODE_PAIRBS;
          end
        end
      end
      MODE_PAIRBS: begin
        if (byte_i == CharBslash) begin
          mode_d = MODE_PAIRU;
        end else begin
          high_d = '0;
          mode_d = t_mode;
          fin    = t_end;
        end
      end
      MODE_PAIRU: begin
        if (byte_i == CharU) begin
          hex_value_d = '0;
          hex_count_d = '0;
          hex_bad_d   = 1'b0;
          mode_d      = MODE_HEXLO;
        end else begin
          high_d = '0;
          mode_d = e_mode;
          fin    = e_end;
        end
      end
      default: begin
        mode_d = MODE_WAIT;
        if (byte_i == CharQuote) begin
          hex_value_d = '0;
          hex_count_d = '0;
          hex_bad_d   = 1'b0;
          high_d      = '0;
          mode_d      = MODE_TEXT;
        end
      end
    endcase
    if (fin) begin
      mode_d      = MODE_WAIT;
      hex_value_d = '0;
      hex_count_d = '0;
      hex_bad_d   = 1'b0;
      high_d      = '0;
    end
  end

  // outputs
  always_comb begin
    push  = 1'b0;
    cmd_o = '{kind: KIND_DATA, len: 2'd0, cp: 21'd0};
    case (mode_q)
      MODE_TEXT: begin
        push  = t_push;
        cmd_o = t_cmd;
      end
      MODE_ESC: begin
        push  = e_push;
        cmd_o = e_cmd;
      end
      MODE_HEXHI, MODE_HEXLO: begin
        if (byte_i == CharNul) begin
          push  = 1'b1;
          cmd_o = '{kind: KIND_NUL, len: 2'd0, cp: 21'd0};
        end else if (hex_done) begin
          if (mode_q == MODE_HEXHI) begin
            push  = ~v_zero & ~v_low & ~v_high;
            cmd_o = '{kind: KIND_DATA, len: utf8_len({5'd0, v}), cp: {5'd0, v}};
          end else begin
            push  = v_low;
            cmd_o = '{kind: KIND_DATA, len: utf8_len(pair_cp), cp: pair_cp};
          end
        end
      end
      MODE_PAIRBS: begin
        push  = (byte_i != CharBslash) & t_push;
        cmd_o = t_cmd;
      end
      MODE_PAIRU: begin
        push  = (byte_i != CharU) & e_push;
        cmd_o = e_cmd;
      end
      default: begin
        push  = (byte_i != CharQuote);
        cmd_o = '{kind: KIND_NOSTR, len: 2'd0, cp: 21'd0};
      end
    endcase
  end

  assign push_o = accept_i & push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_WAIT;
      hex_value_q <= '0;
      hex_count_q <= '0;
      hex_bad_q   <= 1'b0;
      high_q      <= '0;
    end else if (accept_i) begin
      mode_q      <= mode_d;
      hex_value_q <= hex_value_d;
      hex_count_q <= hex_count_d;
      hex_bad_q   <= hex_bad_d;
      high_q      <= high_d;
    end
  end

endmodule

// ===== rtl/jsu_queue.sv =====
// Small command queue between front and back end.
// Depends on jsu_pkg for cmd_t.
`timescale 1ns / 1ps

module jsu_queue import jsu_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t data_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/jsu_back.sv =====
// Back end: expands queued commands into UTF-8 bytes and terminators,
// one word per cycle while the output is free, into a registered output stage. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_data_i,
  output logic       q_pop_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,
  output kind_e      m_tuser_o,
  output logic       m_tlast_o
);

  logic       cur_valid_q, cur_valid_d;
  cmd_t       cur_q;
  logic [1:0] idx_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  kind_e      out_kind_q;
  logic       out_last_q;

  logic       out_free, advance, is_last, cur_done, load;
  logic [7:0] gen_byte;

  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [1:0] len,
                                           logic [1:0] idx);
    logic [1:0] rest;
    logic [5:0] cont;
    rest = len - idx;
    case (rest)
      2'd0:    cont = cp[5:0];
      2'd1:    cont = cp[11:6];
      2'd2:    cont = cp[17:12];
      default: cont = 6'd0;
    endcase
    if (idx != 2'd0) begin
      return {2'b10, cont};
    end
    case (len)
      2'd0:    return cp[7:0];
      2'd1:    return {3'b110, cp[10:6]};
      2'd2:    return {4'b1110, cp[15:12]};
      default: return {5'b11110, cp[20:18]};
    endcase
  endfunction

  always_comb begin
    out_free = ~out_valid_q | m_tready_i;
    advance  = cur_valid_q & out_free;
    is_last  = (idx_q == cur_q.len);
    cur_done = advance & is_last;
    load     = q_valid_i & (~cur_valid_q | cur_done);
    gen_byte = (cur_q.kind == KIND_DATA) ? utf8_byte(cur_q.cp, cur_q.len, idx_q) : 8'd0;

    cur_valid_d = cur_valid_q;
    if (load) begin
      cur_valid_d = 1'b1;
    end else if (cur_done) begin
      cur_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign q_pop_o    = load;
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_byte_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
      if (load) begin
        idx_q <= '0;
      end else if (advance) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_data_i;
    end
    if (advance) begin
      out_byte_q <= gen_byte;
      out_kind_q <= cur_q.kind;
      out_last_q <= is_last;
    end
  end

  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> idx_q <= cur_q.len)
    else $error("byte index past end of command");

  a_term_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && cur_q.kind != KIND_DATA |-> cur_q.len == 2'd0)
    else $error("terminator command spans more than one word");

  a_rest_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tready_i && !m_tlast_o |-> cur_valid_q)
    else $error("sequence cut before its last word");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");

endmodule

// ===== rtl/json_string_unescape.sv =====
// Top level of the JSON string unescaper: front end, command queue, back end.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// Input stream: one byte of JSON text per word on s_tdata_i, starting at
// the opening quote. Output stream: decoded bytes on m_tdata_o, with the
// word kind on m_tuser_o (data, closed by quote, ended by NUL, not a
// string) and m_tlast_o marking the final word caused by one input byte.
// An input byte that gives no output (opening quote, backslash, hex digits,
// dropped surrogates) is simply absorbed.
//
// Throughput: one input word per cycle while the queue has room. Each input
// byte produces at most one command; the back end emits one word per cycle
// while the receiver takes them, so a code point of N UTF-8 bytes gives N words.
// Results pass the queue, the command register and the output register.
//
// When the receiver stalls, the output register holds, the back end waits
// and the queue (QueueDepth commands) absorbs input until full, at which
// point s_tready_o drops. Reset empties the queue and output and returns
// the decoder to waiting for an opening quote.
`timescale 1ns / 1ps

module json_string_unescape import jsu_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // [7:0] in_byte
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // [7:0] out_byte
  output logic [1:0] m_tuser_o,   // [1:0] kind
  output logic       m_tlast_o
);

  logic  q_full, q_push, q_valid, q_pop, accept;
  cmd_t  push_cmd, head_cmd;
  kind_e out_kind;

  assign s_tready_o = ~q_full;
  assign accept     = s_tvalid_i & ~q_full;
  assign m_tuser_o  = out_kind;

  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_tdata_i),
    .push_o   (q_push),
    .cmd_o    (push_cmd)
  );

  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (head_cmd),
    .pop_i   (q_pop)
  );

  jsu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (head_cmd),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (out_kind),
    .m_tlast_o  (m_tlast_o)
  );

endmodule
